// ===== rtl/fcm_pkg.sv =====
// shared types and constants of the cluster chain manager
`default_nettype none

package fcm_pkg;

  localparam int unsigned ENTRY_W   = 11;
  localparam int unsigned CLUSTER_W = 10;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned STATUS_W  = 2;

  localparam logic [ENTRY_W-1:0] FREE_MARK = 11'd1024;
  localparam logic [ENTRY_W-1:0] END_MARK  = 11'd1025;
  localparam logic [ENTRY_W-1:0] BAD_MARK  = 11'd1026;
  localparam logic [ENTRY_W-1:0] MAX_LIMIT = 11'd1024;

  localparam logic [ACTION_W-1:0] ACT_LIST   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_RUN    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_TAIL   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_FREE   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BROKEN  = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_FREE,
    S_LINK_END,
    S_READ,
    S_RESULT,
    S_EMIT_RD,
    S_EMIT_WR
  } fcm_state_t;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [COUNT_W-1:0]   count;
    logic [CLUSTER_W-1:0] head_cluster;
    logic [ENTRY_W-1:0]   entry_value;
  } fcm_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [CLUSTER_W-1:0] cluster;
    logic [ENTRY_W-1:0]   entry_read;
    logic                 last;
  } fcm_res_t;

endpackage

`default_nettype wire

// ===== rtl/fat_cluster_chain_manager.sv =====
// Cluster chain manager over a file allocation table held in on-chip ram.
// After reset the table is cleared to free one entry a cycle, min(TABLE_DEPTH, 1024)
// entries in all, during which no request is taken. A free-list or run request scans
// the table one entry per cycle up to the active cluster count, then delivers its
// results one at a time through a read and an emit state, holding while the output
// stage is full. Tail search and chain freeing follow one link per cycle (at most
// the active count plus one links); append adds a free scan after the walk and a
// link-end step to mark the new chain end. Write goes from idle to the result state;
// read passes a read state first. The single read port paces each scan and walk.
`default_nettype none

module fat_cluster_chain_manager
  import fcm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned MAX_REQUEST = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data,    // clusters_in_use
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,     // count, start cluster, entry_value, zero fill
  input  wire logic [2:0]  s_tuser,     // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,     // cluster, entry_read, zero fill
  output logic [1:0]       m_tuser,     // status
  output logic             m_tlast
);

  localparam int unsigned MEM_DEPTH = (TABLE_DEPTH < 1024) ? TABLE_DEPTH : 1024;
  localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned BUF_AW    = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1;

  logic [ENTRY_W-1:0]   clusters_in_use;
  fcm_req_t             req;
  fcm_res_t             res;
  logic                 push;
  logic                 out_free;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [ENTRY_W-1:0]   ram_q;
  logic [ENTRY_W-1:0]   mem_rdata;
  logic                 fwd_hit;
  logic [ENTRY_W-1:0]   fwd_data;
  logic                 buf_we;
  logic [BUF_AW-1:0]    buf_waddr;
  logic [CLUSTER_W-1:0] buf_wdata;
  logic [BUF_AW-1:0]    buf_raddr;
  logic [CLUSTER_W-1:0] buf_rdata;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      clusters_in_use <= MAX_LIMIT;
    end else if (cfg_valid) begin
      clusters_in_use <= cfg_data;
    end
  end

  assign req = '{action: s_tuser, count: s_tdata[6:0], head_cluster: s_tdata[16:7],
                 entry_value: s_tdata[27:17]};

  // same-cycle write to the entry being read
  always_ff @(posedge clk) begin
    fwd_hit  <= mem_we && (mem_waddr == mem_raddr);
    fwd_data <= mem_wdata;
  end

  assign mem_rdata = fwd_hit ? fwd_data : ram_q;

  fcm_ram #(.WIDTH(ENTRY_W), .DEPTH(MEM_DEPTH)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (ram_q)
  );

  fcm_ram #(.WIDTH(CLUSTER_W), .DEPTH(MAX_REQUEST)) u_found (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  fcm_ctrl #(.MEM_DEPTH(MEM_DEPTH), .MAX_REQUEST(MAX_REQUEST)) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .clusters_in_use (clusters_in_use),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .req             (req),
    .out_free        (out_free),
    .push            (push),
    .res             (res),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata),
    .buf_we          (buf_we),
    .buf_waddr       (buf_waddr),
    .buf_wdata       (buf_wdata),
    .buf_raddr       (buf_raddr),
    .buf_rdata       (buf_rdata)
  );

  // output register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (push) begin
      m_tdata <= {3'b000, res.entry_read, res.cluster};
      m_tuser <= res.status;
      m_tlast <= res.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fcm_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module fcm_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic      [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/fcm_ctrl.sv =====
// request sequencer: table clearing, scans, chain walks and result ordering
`default_nettype none

module fcm_ctrl
  import fcm_pkg::*;
#(
  parameter int unsigned MEM_DEPTH   = 1024,
  parameter int unsigned MAX_REQUEST = 64,
  localparam int unsigned AW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1,
  localparam int unsigned BUF_AW = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [ENTRY_W-1:0]   clusters_in_use,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire fcm_req_t             req,
  input  wire logic                 out_free,
  output logic                      push,
  output fcm_res_t                  res,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic [ENTRY_W-1:0]        mem_wdata,
  output logic [AW-1:0]             mem_raddr,
  input  wire logic [ENTRY_W-1:0]   mem_rdata,
  output logic                      buf_we,
  output logic [BUF_AW-1:0]         buf_waddr,
  output logic [CLUSTER_W-1:0]      buf_wdata,
  output logic [BUF_AW-1:0]         buf_raddr,
  input  wire logic [CLUSTER_W-1:0] buf_rdata
);

  localparam logic [ENTRY_W-1:0] DEPTH_LIM = ENTRY_W'(MEM_DEPTH);
  localparam logic [COUNT_W-1:0] MAX_CNT   = COUNT_W'(MAX_REQUEST);
  localparam logic [AW-1:0]      LAST_ADDR = AW'(MEM_DEPTH - 1);

  fcm_state_t state, state_next;
  logic [ACTION_W-1:0]  act, act_next;
  logic [COUNT_W-1:0]   cnt, cnt_next;
  logic [CLUSTER_W-1:0] cur, cur_next;
  logic [ENTRY_W-1:0]   idx, idx_next;
  logic                 chk_vld, chk_vld_next;
  logic [CLUSTER_W-1:0] chk_idx, chk_idx_next;
  logic [COUNT_W-1:0]   n, n_next;
  logic [ENTRY_W-1:0]   steps, steps_next;
  logic [CLUSTER_W-1:0] tail, tail_next;
  logic [CLUSTER_W-1:0] base, base_next;
  logic [COUNT_W-1:0]   k, k_next;
  logic [STATUS_W-1:0]  r_status, r_status_next;
  logic [CLUSTER_W-1:0] r_cluster, r_cluster_next;
  logic [ENTRY_W-1:0]   r_entry, r_entry_next;
  logic [AW-1:0]        clr, clr_next;
  logic [ENTRY_W-1:0]   lim;
  logic                 start_bad;
  logic                 count_bad;

  assign lim       = (clusters_in_use > DEPTH_LIM) ? DEPTH_LIM : clusters_in_use;
  assign start_bad = ({1'b0, req.head_cluster} >= lim);
  assign count_bad = (req.count == '0) || (req.count > MAX_CNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
    act       <= act_next;
    cnt       <= cnt_next;
    cur       <= cur_next;
    idx       <= idx_next;
    chk_vld   <= chk_vld_next;
    chk_idx   <= chk_idx_next;
    n         <= n_next;
    steps     <= steps_next;
    tail      <= tail_next;
    base      <= base_next;
    k         <= k_next;
    r_status  <= r_status_next;
    r_cluster <= r_cluster_next;
    r_entry   <= r_entry_next;
  end

  always_comb begin
    state_next     = state;
    act_next       = act;
    cnt_next       = cnt;
    cur_next       = cur;
    idx_next       = idx;
    chk_vld_next   = chk_vld;
    chk_idx_next   = chk_idx;
    n_next         = n;
    steps_next     = steps;
    tail_next      = tail;
    base_next      = base;
    k_next         = k;
    r_status_next  = r_status;
    r_cluster_next = r_cluster;
    r_entry_next   = r_entry;
    clr_next       = clr;
    in_ready       = 1'b0;
    push           = 1'b0;
    res            = '{status: ST_OK, cluster: '0, entry_read: '0, last: 1'b1};
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = FREE_MARK;
    mem_raddr      = '0;
    buf_we         = 1'b0;
    buf_waddr      = n[BUF_AW-1:0];
    buf_wdata      = chk_idx;
    buf_raddr      = k[BUF_AW-1:0];

    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr;
        clr_next  = clr + 1'b1;
        if (clr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready       = 1'b1;
        mem_raddr      = req.head_cluster[AW-1:0];
        if (in_valid) begin
          act_next       = req.action;
          cnt_next       = req.count;
          cur_next       = req.head_cluster;
          idx_next       = '0;
          chk_vld_next   = 1'b0;
          n_next         = '0;
          steps_next     = '0;
          k_next         = '0;
          r_status_next  = ST_INVALID;
          r_cluster_next = '0;
          r_entry_next   = '0;
          state_next     = S_RESULT;
          priority case (1'b1)
            (req.action == ACT_LIST) || (req.action == ACT_RUN): begin
              if (!count_bad) begin
                state_next = S_SCAN;
              end
            end
            (req.action == ACT_TAIL) || (req.action == ACT_APPEND): begin
              if (!start_bad) begin
                state_next = S_WALK;
              end
            end
            (req.action == ACT_FREE): begin
              if (!start_bad) begin
                state_next = S_FREE;
              end
            end
            (req.action == ACT_WRITE): begin
              if (!start_bad && req.entry_value <= BAD_MARK) begin
                mem_we         = 1'b1;
                mem_waddr      = req.head_cluster[AW-1:0];
                mem_wdata      = req.entry_value;
                r_status_next  = ST_OK;
                r_cluster_next = req.head_cluster;
              end
            end
            (req.action == ACT_READ): begin
              if (!start_bad) begin
                state_next = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        mem_raddr    = idx[AW-1:0];
        chk_vld_next = (idx < lim);
        chk_idx_next = idx[CLUSTER_W-1:0];
        if (idx < lim) begin
          idx_next = idx + 1'b1;
        end
        if (chk_vld) begin
          if (mem_rdata == FREE_MARK) begin
            n_next = n + 1'b1;
            if (act == ACT_APPEND) begin
              mem_we         = 1'b1;
              mem_waddr      = tail[AW-1:0];
              mem_wdata      = {1'b0, chk_idx};
              r_cluster_next = chk_idx;
              state_next     = S_LINK_END;
            end else begin
              if (act == ACT_LIST) begin
                buf_we = 1'b1;
              end
              if (n + 1'b1 == cnt) begin
                base_next  = CLUSTER_W'(chk_idx + 10'd1 - {3'b000, cnt});
                state_next = S_EMIT_RD;
              end
            end
          end else if (act == ACT_RUN) begin
            n_next = '0;
          end
        end else if (idx >= lim) begin
          r_status_next  = ST_NO_FREE;
          r_cluster_next = '0;
          state_next     = S_RESULT;
        end
      end

      S_WALK: begin
        mem_raddr = mem_rdata[AW-1:0];
        if (mem_rdata == END_MARK) begin
          tail_next = cur;
          if (act == ACT_TAIL) begin
            r_status_next  = ST_OK;
            r_cluster_next = cur;
            state_next     = S_RESULT;
          end else begin
            idx_next     = '0;
            chk_vld_next = 1'b0;
            state_next   = S_SCAN;
          end
        end else if (mem_rdata >= lim || steps == lim) begin
          r_status_next  = ST_BROKEN;
          r_cluster_next = '0;
          state_next     = S_RESULT;
        end else begin
          cur_next   = mem_rdata[CLUSTER_W-1:0];
          steps_next = steps + 1'b1;
        end
      end

      S_FREE: begin
        mem_raddr      = mem_rdata[AW-1:0];
        mem_we         = 1'b1;
        mem_waddr      = cur[AW-1:0];
        mem_wdata      = FREE_MARK;
        r_cluster_next = '0;
        if (mem_rdata == END_MARK || mem_rdata == FREE_MARK || mem_rdata == BAD_MARK) begin
          r_status_next = ST_OK;
          state_next    = S_RESULT;
        end else if (mem_rdata >= lim) begin
          r_status_next = ST_BROKEN;
          state_next    = S_RESULT;
        end else if (steps == lim) begin
          r_status_next = ST_OK;
          state_next    = S_RESULT;
        end else begin
          cur_next   = mem_rdata[CLUSTER_W-1:0];
          steps_next = steps + 1'b1;
        end
      end

      S_LINK_END: begin
        mem_we        = 1'b1;
        mem_waddr     = r_cluster[AW-1:0];
        mem_wdata     = END_MARK;
        r_status_next = ST_OK;
        state_next    = S_RESULT;
      end

      S_READ: begin
        r_status_next  = ST_OK;
        r_cluster_next = cur;
        r_entry_next   = mem_rdata;
        state_next     = S_RESULT;
      end

      S_RESULT: begin
        if (out_free) begin
          push       = 1'b1;
          res        = '{status: r_status, cluster: r_cluster, entry_read: r_entry, last: 1'b1};
          state_next = S_IDLE;
        end
      end

      S_EMIT_RD: begin
        state_next = S_EMIT_WR;
      end

      S_EMIT_WR: begin
        if (out_free) begin
          push        = 1'b1;
          res.status  = ST_OK;
          res.cluster = (act == ACT_LIST) ? buf_rdata
                                          : CLUSTER_W'(base + {3'b000, k});
          res.last    = (k + 1'b1 == cnt);
          k_next      = k + 1'b1;
          state_next  = res.last ? S_IDLE : S_EMIT_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free) else $error("result pushed into a full output stage");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (push && res.last) |=> (state == S_IDLE)) else $error("request not closed after final result");

  a_scan_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && act != ACT_APPEND) |-> (n < cnt)) else $error("scan overran count");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK || state == S_FREE) |-> (steps <= lim)) else $error("walk past bound");
`endif

endmodule

`default_nettype wire
